// ----- rtl/hduart_pkg.sv -----
// types, codes and helpers shared by the half-duplex uart transceiver
package hduart_pkg;

	// request kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_TX   = 2'd1;
	localparam logic [1:0] KIND_RX   = 2'd2;

	// parity modes
	localparam logic [1:0] PAR_NONE = 2'd0;
	localparam logic [1:0] PAR_EVEN = 2'd1;
	localparam logic [1:0] PAR_ODD  = 2'd2;

	// receive status codes
	localparam logic [1:0] RX_OK       = 2'd0;
	localparam logic [1:0] RX_TIMEOUT  = 2'd1;
	localparam logic [1:0] RX_FRAMING  = 2'd2;
	localparam logic [1:0] RX_PARITY   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_BIT_PERIOD    = 2'd0;
	localparam logic [1:0] REG_PARITY_MODE   = 2'd1;
	localparam logic [1:0] REG_TWO_STOP      = 2'd2;
	localparam logic [1:0] REG_START_TIMEOUT = 2'd3;

	localparam int FRAME_W = 12;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx_byte;
		logic       line_level;
	} uart_in_t;

	typedef struct packed {
		logic        line_out;
		logic        drive_enable;
		logic        busy_res;
		logic        tx_done;
		logic        rx_done;
		logic [7:0]  rx_byte;
		logic [1:0]  rx_status;
		logic [31:0] timeout_count;
		logic [31:0] framing_count;
		logic [31:0] parity_count;
	} uart_out_t;

	function automatic logic parity_enabled(input logic [1:0] mode);
		return (mode == PAR_EVEN) || (mode == PAR_ODD);
	endfunction

	function automatic logic parity_of(input logic [7:0] v, input logic [1:0] mode);
		return (^v) ^ (mode == PAR_ODD);
	endfunction

endpackage

// ----- rtl/half_duplex_uart_transceiver.sv -----
// Half-duplex single-wire uart transceiver timed by microsecond tick requests. For each
// accepted request the frame state machine updates from the current state and the
// request in a single pass and the result lands in a registered output with a one-entry skid
// stage behind it, so the block accepts one request per cycle until the skid stage fills,
// and keeps accepting while a single result waits. A transmit sends a guard bit, start,
// DATA_BITS data bits LSB first, optional parity and one or two stops;
// a receive waits for a low line up to the start timeout, samples three quarters into the
// start bit and into every bit after it, and reports a status plus wrapping error counters.
module half_duplex_uart_transceiver #(
	parameter int DATA_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [31:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hduart_pkg::uart_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hduart_pkg::uart_out_t out_data
);
	import hduart_pkg::*;

	localparam logic [7:0] DATA_MASK = 8'((1 << DATA_BITS) - 1);
	localparam logic [3:0] FRAME_BASE = 4'(2 + DATA_BITS);
	localparam logic [3:0] PAR_POS = 4'(1 + DATA_BITS);

	typedef enum logic [1:0] {PH_IDLE, PH_TX, PH_RXWAIT, PH_RXSAMP} phase_t;

	// configuration
	logic [19:0] bit_period_q;
	logic [1:0]  parity_mode_q;
	logic        two_stop_q;
	logic [31:0] start_timeout_q;

	// frame state
	phase_t             phase_q, phase_d;
	logic [31:0]        timer_q, timer_d;
	logic [FRAME_W-1:0] frame_q, frame_d;
	logic [3:0]         bit_idx_q, bit_idx_d;
	logic               drive_level_q, drive_level_d;
	logic [31:0]        timeouts_q, timeouts_d;
	logic [31:0]        framing_q, framing_d;
	logic [31:0]        parity_err_q, parity_err_d;

	// output buffering
	logic      out_valid_q, skid_valid_q;
	uart_out_t out_data_q, skid_data_q;
	uart_out_t res;
	logic      accept;

	logic               par_en;
	logic [19:0]        period;
	logic [19:0]        target;
	logic [31:0]        timer_inc;
	logic [3:0]         bit_idx_inc;
	logic [3:0]         tx_total;
	logic [3:0]         rx_nbits;
	logic [7:0]         tx_v;
	logic [7:0]         rx_v;
	logic [3:0]         nxt;
	logic [FRAME_W-1:0] tx_frame;
	logic [FRAME_W-1:0] rx_frame;
	logic               tx_done_d, rx_done_d;
	logic [7:0]         rx_byte_d;
	logic [1:0]         rx_status_d;

	assign in_ready = !skid_valid_q;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign par_en = parity_enabled(parity_mode_q);
	assign period = (bit_period_q == 20'd0) ? 20'd1 : bit_period_q;
	assign target = (bit_idx_q == 4'd0) ? (period - (period >> 2)) : period;
	assign timer_inc = timer_q + 32'd1;
	assign bit_idx_inc = bit_idx_q + 4'd1;
	assign tx_total = FRAME_BASE + {3'd0, par_en} + (two_stop_q ? 4'd2 : 4'd1);
	assign rx_nbits = FRAME_BASE + {3'd0, par_en};
	assign tx_v = in_data.tx_byte & DATA_MASK;

	// transmit frame: start at bit 0, data, parity, stops
	always_comb begin
		tx_frame = FRAME_W'({tx_v, 1'b0});
		nxt = PAR_POS;
		if (par_en) begin
			tx_frame[nxt] = parity_of(tx_v, parity_mode_q);
			nxt = nxt + 4'd1;
		end
		tx_frame = tx_frame | (FRAME_W'(1) << nxt);
		if (two_stop_q) begin
			tx_frame = tx_frame | (FRAME_W'(1) << (nxt + 4'd1));
		end
	end

	// receive frame with this tick's sample folded in
	always_comb begin
		rx_frame = frame_q;
		if (bit_idx_q < 4'd12 && in_data.line_level) begin
			rx_frame = rx_frame | (FRAME_W'(1) << bit_idx_q);
		end
		rx_v = rx_frame[8:1] & DATA_MASK;
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		frame_d = frame_q;
		bit_idx_d = bit_idx_q;
		drive_level_d = drive_level_q;
		timeouts_d = timeouts_q;
		framing_d = framing_q;
		parity_err_d = parity_err_q;
		tx_done_d = 1'b0;
		rx_done_d = 1'b0;
		rx_byte_d = 8'd0;
		rx_status_d = RX_OK;
		if (in_data.kind == KIND_TX && phase_q == PH_IDLE) begin
			phase_d = PH_TX;
			frame_d = tx_frame;
			timer_d = 32'd0;
			bit_idx_d = 4'd0;
			drive_level_d = 1'b1;
		end else if (in_data.kind == KIND_RX && phase_q == PH_IDLE) begin
			phase_d = PH_RXWAIT;
			timer_d = 32'd0;
			frame_d = '0;
			bit_idx_d = 4'd0;
		end else if (in_data.kind == KIND_TICK) begin
			unique case (phase_q)
				PH_TX: begin
					timer_d = timer_inc;
					if (timer_inc >= {12'd0, period}) begin
						timer_d = 32'd0;
						bit_idx_d = bit_idx_inc;
						if (bit_idx_inc >= tx_total) begin
							phase_d = PH_IDLE;
							drive_level_d = 1'b1;
							bit_idx_d = 4'd0;
							tx_done_d = 1'b1;
						end else if (bit_idx_inc == 4'd0 || bit_idx_inc > 4'd12) begin
							drive_level_d = 1'b1;
						end else begin
							drive_level_d = frame_q[bit_idx_inc - 4'd1];
						end
					end
				end
				PH_RXWAIT: begin
					if (!in_data.line_level) begin
						phase_d = PH_RXSAMP;
						timer_d = 32'd0;
						bit_idx_d = 4'd0;
						frame_d = '0;
					end else if (timer_q >= start_timeout_q) begin
						phase_d = PH_IDLE;
						timer_d = 32'd0;
						timeouts_d = timeouts_q + 32'd1;
						rx_done_d = 1'b1;
						rx_status_d = RX_TIMEOUT;
					end else begin
						timer_d = timer_inc;
					end
				end
				PH_RXSAMP: begin
					timer_d = timer_inc;
					if (timer_inc >= {12'd0, target}) begin
						timer_d = 32'd0;
						frame_d = rx_frame;
						bit_idx_d = bit_idx_inc;
						if (bit_idx_inc >= rx_nbits) begin
							phase_d = PH_IDLE;
							bit_idx_d = 4'd0;
							rx_done_d = 1'b1;
							if (rx_frame[0] || !rx_frame[rx_nbits - 4'd1]) begin
								framing_d = framing_q + 32'd1;
								rx_status_d = RX_FRAMING;
							end else if (par_en &&
								rx_frame[PAR_POS] != parity_of(rx_v, parity_mode_q)) begin
								parity_err_d = parity_err_q + 32'd1;
								rx_status_d = RX_PARITY;
							end else begin
								rx_byte_d = rx_v;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.line_out = drive_level_d;
		res.drive_enable = (phase_d == PH_TX);
		res.busy_res = (phase_d != PH_IDLE);
		res.tx_done = tx_done_d;
		res.rx_done = rx_done_d;
		res.rx_byte = rx_byte_d;
		res.rx_status = rx_status_d;
		res.timeout_count = timeouts_d;
		res.framing_count = framing_d;
		res.parity_count = parity_err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= 20'd52;
			parity_mode_q <= PAR_NONE;
			two_stop_q <= 1'b0;
			start_timeout_q <= 32'd1000;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BIT_PERIOD:    bit_period_q <= cfg_wdata[19:0];
				REG_PARITY_MODE:   parity_mode_q <= cfg_wdata[1:0];
				REG_TWO_STOP:      two_stop_q <= cfg_wdata[0];
				REG_START_TIMEOUT: start_timeout_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= 32'd0;
			frame_q <= '0;
			bit_idx_q <= 4'd0;
			drive_level_q <= 1'b1;
			timeouts_q <= 32'd0;
			framing_q <= 32'd0;
			parity_err_q <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			frame_q <= frame_d;
			bit_idx_q <= bit_idx_d;
			drive_level_q <= drive_level_d;
			timeouts_q <= timeouts_d;
			framing_q <= framing_d;
			parity_err_q <= parity_err_d;
		end
	end

	// result register with a one-entry skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (accept) begin
				out_data_q <= res;
			end
		end else if (accept) begin
			skid_data_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register empty");

	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_TX) |-> drive_level_q)
		else $error("line level low outside a transmit");

	a_drive_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_data_q.drive_enable || out_data_q.busy_res))
		else $error("drive enable without busy");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_data_q.tx_done || out_data_q.rx_done)) |->
			!out_data_q.busy_res)
		else $error("done reported while still busy");
`endif

endmodule

// ----- tb/half_duplex_uart_transceiver_tb.sv -----
// self-checking testbench for the half-duplex uart transceiver
`timescale 1ns / 1ps

module half_duplex_uart_transceiver_tb;
	import hduart_pkg::*;

	localparam int DATA_W = 8;
	localparam int STUCK_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 350;

	// codes the package leaves unnamed
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [1:0] PAR_RESERVED = 2'd3;

	typedef enum logic [1:0] {LINK_IDLE, LINK_TX, LINK_RX_WAIT, LINK_RX_SAMPLE} link_state_e;
	typedef enum logic [1:0] {FRAME_CLEAN, FRAME_BAD_PARITY, FRAME_BAD_STOP} frame_fault_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = REG_BIT_PERIOD;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	uart_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	uart_out_t   out_data;

	half_duplex_uart_transceiver #(
		.DATA_BITS(DATA_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted link state and register copies
	link_state_e       ph;
	logic [31:0]       tick_cnt;
	logic [11:0]       frame_bits;
	logic [3:0]        bit_pos;
	logic              wire_lvl;
	logic [31:0]       n_timeouts, n_framing, n_parity;
	logic [19:0]       cur_period;
	logic [1:0]        cur_parity;
	logic              cur_two_stop;
	logic [31:0]       cur_timeout;

	uart_out_t expected_q[$];
	int fail_count = 0;
	int work_items = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stuck_cycles = 0;

	function automatic void reset_link_model();
		ph = LINK_IDLE;
		tick_cnt = '0;
		frame_bits = '0;
		bit_pos = '0;
		wire_lvl = 1'b1;
		n_timeouts = '0;
		n_framing = '0;
		n_parity = '0;
		cur_period = 20'd52;
		cur_parity = PAR_NONE;
		cur_two_stop = 1'b0;
		cur_timeout = 32'd1000;
	endfunction

	function automatic logic par_on();
		return (cur_parity == PAR_EVEN) || (cur_parity == PAR_ODD);
	endfunction

	function automatic logic data_parity(input logic [DATA_W-1:0] v);
		logic odd_sense;
		odd_sense = (cur_parity == PAR_ODD);
		return (^v) ^ odd_sense;
	endfunction

	function automatic int bit_ticks();
		return (cur_period == 0) ? 1 : int'(cur_period);
	endfunction

	// advances the link model by one request and returns the expected result
	function automatic uart_out_t predict_step(input uart_in_t req);
		uart_out_t r;
		logic [DATA_W-1:0] v;
		logic [31:0] p, target;
		int nxt, total, nbits, stops;
		r = '0;
		stops = cur_two_stop ? 2 : 1;
		p = bit_ticks();
		if (req.kind == KIND_TX && ph == LINK_IDLE) begin
			v = req.tx_byte[DATA_W-1:0];
			frame_bits = '0;
			frame_bits[DATA_W:1] = v;
			nxt = DATA_W + 1;
			if (par_on()) begin
				frame_bits[nxt] = data_parity(v);
				nxt++;
			end
			for (int i = 0; i < stops; i++)
				frame_bits[nxt + i] = 1'b1;
			ph = LINK_TX;
			tick_cnt = '0;
			bit_pos = '0;
			wire_lvl = 1'b1;
		end else if (req.kind == KIND_RX && ph == LINK_IDLE) begin
			ph = LINK_RX_WAIT;
			tick_cnt = '0;
			frame_bits = '0;
			bit_pos = '0;
		end else if (req.kind == KIND_TICK) begin
			case (ph)
				LINK_TX: begin
					total = 2 + DATA_W + par_on() + stops;
					tick_cnt++;
					if (tick_cnt >= p) begin
						tick_cnt = '0;
						bit_pos = bit_pos + 4'd1;
						if (bit_pos >= total) begin
							ph = LINK_IDLE;
							wire_lvl = 1'b1;
							bit_pos = '0;
							r.tx_done = 1'b1;
						end else begin
							// guard bit sits before the frame
							wire_lvl = (bit_pos == 0 || bit_pos > 12) ? 1'b1
								: frame_bits[bit_pos - 1];
						end
					end
				end
				LINK_RX_WAIT: begin
					if (!req.line_level) begin
						ph = LINK_RX_SAMPLE;
						tick_cnt = '0;
						bit_pos = '0;
						frame_bits = '0;
					end else if (tick_cnt >= cur_timeout) begin
						ph = LINK_IDLE;
						tick_cnt = '0;
						n_timeouts++;
						r.rx_done = 1'b1;
						r.rx_status = RX_TIMEOUT;
					end else begin
						tick_cnt++;
					end
				end
				LINK_RX_SAMPLE: begin
					// start bit and every later bit sampled three quarters in
					target = (bit_pos == 0) ? p - p / 4 : p;
					nbits = 2 + DATA_W + par_on();
					tick_cnt++;
					if (tick_cnt >= target) begin
						tick_cnt = '0;
						if (bit_pos < 12 && req.line_level)
							frame_bits[bit_pos] = 1'b1;
						bit_pos = bit_pos + 4'd1;
						if (bit_pos >= nbits) begin
							v = frame_bits[DATA_W:1];
							ph = LINK_IDLE;
							bit_pos = '0;
							r.rx_done = 1'b1;
							if (frame_bits[0] || !frame_bits[nbits - 1]) begin
								n_framing++;
								r.rx_status = RX_FRAMING;
							end else if (par_on() &&
								frame_bits[1 + DATA_W] != data_parity(v)) begin
								n_parity++;
								r.rx_status = RX_PARITY;
							end else begin
								r.rx_status = RX_OK;
								r.rx_byte = v;
							end
						end
					end
				end
				default: ;
			endcase
		end
		r.line_out = wire_lvl;
		r.drive_enable = (ph == LINK_TX);
		r.busy_res = (ph != LINK_IDLE);
		r.timeout_count = n_timeouts;
		r.framing_count = n_framing;
		r.parity_count = n_parity;
		return r;
	endfunction

	task automatic send_item(input logic [1:0] kind, input logic [7:0] data, input logic line);
		uart_in_t req;
		int gap;
		req.kind = kind;
		req.tx_byte = data;
		req.line_level = line;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (kind == KIND_TICK || (ph == LINK_IDLE && (kind == KIND_TX || kind == KIND_RX)))
			work_items++;
		expected_q.push_back(predict_step(req));
	endtask

	// a tick, now and then preceded by a request the block should ignore
	task automatic tick(input logic line);
		if ($urandom_range(0, 99) < 3) begin
			if (ph != LINK_IDLE)
				send_item(2'($urandom_range(KIND_TX, KIND_NONE)), 8'($urandom),
					1'($urandom_range(0, 1)));
			else
				send_item(KIND_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
		end
		send_item(KIND_TICK, 8'($urandom), line);
	endtask

	task automatic drain();
		while (ph != LINK_IDLE)
			tick(1'($urandom_range(0, 1)));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_q.size() != 0);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BIT_PERIOD: cur_period = value[19:0];
			REG_PARITY_MODE: cur_parity = value[1:0];
			REG_TWO_STOP: cur_two_stop = value[0];
			REG_START_TIMEOUT: cur_timeout = value;
			default: ;
		endcase
	endtask

	task automatic tx_frame(input logic [7:0] d);
		send_item(KIND_TX, d, 1'($urandom_range(0, 1)));
		drain();
	endtask

	// receive request, idle lead-in, then a frame driven on the line
	task automatic rx_frame(input logic [7:0] d, input int lead, input int flip_pct,
		input frame_fault_e fault);
		logic [11:0] wave;
		int nb;
		send_item(KIND_RX, 8'($urandom), 1'($urandom_range(0, 1)));
		repeat (lead) tick(1'b1);
		wave = '1;
		wave[0] = 1'b0;
		wave[DATA_W:1] = d[DATA_W-1:0];
		nb = DATA_W + 1;
		if (par_on()) begin
			wave[nb] = data_parity(d[DATA_W-1:0]) ^ (fault == FRAME_BAD_PARITY);
			nb++;
		end
		if (fault == FRAME_BAD_STOP)
			wave[nb] = 1'b0;
		nb += cur_two_stop ? 2 : 1;
		for (int b = 0; b < nb; b++)
			repeat (bit_ticks()) tick(wave[b] ^ ($urandom_range(0, 99) < flip_pct));
		drain();
	endtask

	task automatic randomize_setup();
		write_reg(REG_BIT_PERIOD, ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4)
			: $urandom_range(5, 16));
		write_reg(REG_PARITY_MODE, $urandom_range(PAR_NONE, PAR_RESERVED));
		write_reg(REG_TWO_STOP, $urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: write_reg(REG_START_TIMEOUT, 32'd0);
			1: write_reg(REG_START_TIMEOUT, 32'hFFFF_FFFF);
			default: write_reg(REG_START_TIMEOUT, $urandom_range(1, 30));
		endcase
	endtask

	task automatic test_idle_requests();
		tick(1'b0);
		tick(1'b1);
		send_item(KIND_NONE, 8'hFF, 1'b1);
		send_item(KIND_NONE, 8'h00, 1'b0);
	endtask

	task automatic test_transmit();
		write_reg(REG_BIT_PERIOD, 32'd0);
		write_reg(REG_PARITY_MODE, 32'(PAR_EVEN));
		tx_frame(8'hFF);
		write_reg(REG_PARITY_MODE, 32'(PAR_ODD));
		write_reg(REG_TWO_STOP, 32'd1);
		tx_frame(8'h00);
		// requests while a transfer runs must be dropped
		write_reg(REG_BIT_PERIOD, 32'd1);
		send_item(KIND_TX, 8'hA5, 1'b1);
		send_item(KIND_TX, 8'h5A, 1'b0);
		send_item(KIND_RX, 8'h00, 1'b0);
		drain();
		write_reg(REG_PARITY_MODE, 32'(PAR_RESERVED));
		write_reg(REG_TWO_STOP, 32'd0);
		tx_frame(8'h81);
	endtask

	task automatic test_receive();
		write_reg(REG_BIT_PERIOD, 32'd4);
		write_reg(REG_PARITY_MODE, 32'(PAR_EVEN));
		write_reg(REG_START_TIMEOUT, 32'd5);
		rx_frame(8'h3C, 2, 0, FRAME_CLEAN);
		rx_frame(8'hC3, 0, 0, FRAME_BAD_PARITY);
		rx_frame(8'h7E, 1, 0, FRAME_BAD_STOP);
		send_item(KIND_RX, 8'h00, 1'b1);
		repeat (6) tick(1'b1);
		// zero timeout gives up on the first high tick
		write_reg(REG_START_TIMEOUT, 32'd0);
		send_item(KIND_RX, 8'h00, 1'b1);
		tick(1'b1);
		write_reg(REG_BIT_PERIOD, 32'd1000000);
		write_reg(REG_START_TIMEOUT, 32'd3);
		send_item(KIND_RX, 8'h00, 1'b1);
		repeat (4) tick(1'b1);
		write_reg(REG_BIT_PERIOD, 32'd1);
		write_reg(REG_PARITY_MODE, 32'(PAR_NONE));
		write_reg(REG_START_TIMEOUT, 32'hFFFF_FFFF);
		rx_frame(8'h55, 30, 0, FRAME_CLEAN);
		write_reg(REG_BIT_PERIOD, 32'd0);
		rx_frame(8'hAA, 0, 0, FRAME_CLEAN);
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_BIT_PERIOD, 32'd2);
		write_reg(REG_PARITY_MODE, 32'(PAR_NONE));
		hold_reqs++;
		tx_frame(8'($urandom));
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
		int first;
		int cap;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		first = work_items;
		randomize_setup();
		while (work_items - first < count) begin
			if ($urandom_range(0, 5) == 0)
				randomize_setup();
			cap = (cur_timeout > 38) ? 40 : int'(cur_timeout) + 2;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: tx_frame(8'($urandom));
				4, 5, 6, 7, 8: begin
					if ($urandom_range(0, 9) < 7)
						rx_frame(8'($urandom), $urandom_range(0, cap), 0, FRAME_CLEAN);
					else
						rx_frame(8'($urandom), $urandom_range(0, cap),
							$urandom_range(0, 8),
							frame_fault_e'($urandom_range(0, 2)));
				end
				default: repeat (3) tick(1'($urandom_range(0, 1)));
			endcase
		end
	endtask

	initial begin
		reset_link_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_requests();
		test_transmit();
		test_receive();
		test_output_backpressure();
		test_random_traffic(0, 0, PHASE_ITEMS);
		test_random_traffic(79, 0, PHASE_ITEMS);
		test_random_traffic(0, 79, PHASE_ITEMS);
		test_random_traffic(21, 21, PHASE_ITEMS);
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// result side ready, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		uart_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				check_field("line_out", 32'(want.line_out), 32'(out_data.line_out));
				check_field("drive_enable", 32'(want.drive_enable),
					32'(out_data.drive_enable));
				check_field("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
				check_field("tx_done", 32'(want.tx_done), 32'(out_data.tx_done));
				check_field("rx_done", 32'(want.rx_done), 32'(out_data.rx_done));
				check_field("rx_byte", 32'(want.rx_byte), 32'(out_data.rx_byte));
				check_field("rx_status", 32'(want.rx_status), 32'(out_data.rx_status));
				check_field("timeout_count", want.timeout_count, out_data.timeout_count);
				check_field("framing_count", want.framing_count, out_data.framing_count);
				check_field("parity_count", want.parity_count, out_data.parity_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule
